// ===== rtl/wfc_pkg.sv =====
// Shared constants, register indexes and width helpers for the WUDS coefficient block.
package wfc_pkg;

   localparam int RE_LIMIT_DEF = 4096;
   localparam int FRAC_BITS    = 16;
   localparam int WORD_W       = 32;

   // Fixed offsets of the alpha and beta divisions, Q16.16
   localparam longint unsigned ALPHA_OFS = 64'd327680;    // 5.0
   localparam longint unsigned BETA_OFS  = 64'd13107200;  // 200.0

   localparam logic [31:0] CSR_RESET_VAL = 32'd65536;     // 1.0

   typedef enum logic [7:0] {
      CSR_DENSITY   = 8'd0,
      CSR_VISCOSITY = 8'd1,
      CSR_SPACING_X = 8'd2,
      CSR_SPACING_Y = 8'd3
   } csr_index_type;

   // Bits needed to hold the saturated |Re| in Q16.16
   function automatic int re_width(input int limit);
      longint unsigned cap;
      cap = longint'(limit) << FRAC_BITS;
      return $clog2(cap + 64'd1);
   endfunction

endpackage

// ===== rtl/wuds_face_coefficients.sv =====
// Top level: WUDS alpha/beta coefficients for the four faces of a control volume.
// One control volume per word, one word per clock sustained while no result is held at
// the output. Each face runs in its own lane: a multiply front end forms
// |sum|*density*length, a restoring divider retires one bit of |Re| per stage
// (QW = clog2(RE_LIMIT*2^16+1) stages, 29 at the default), then Re^2 is squared in two
// stages and alpha and beta come from two 16-stage dividers side by side. The pipeline
// is QW+26 register stages deep. The whole pipeline holds while a result sits on the
// output with rsp_stall high, so req_stall follows that condition.
// Configuration registers reset to 1.0 and must be written only while no word is
// in flight.
module wuds_face_coefficients import wfc_pkg::*; #(
   parameter int RE_LIMIT = RE_LIMIT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_sum_east,
   input  logic signed [31:0] req_sum_west,
   input  logic signed [31:0] req_sum_north,
   input  logic signed [31:0] req_sum_south,
   input  logic [3:0]         req_use_dy_mask,
   // response words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_alpha_east,
   output logic signed [15:0] rsp_alpha_west,
   output logic signed [15:0] rsp_alpha_north,
   output logic signed [15:0] rsp_alpha_south,
   output logic [16:0]        rsp_beta_east,
   output logic [16:0]        rsp_beta_west,
   output logic [16:0]        rsp_beta_north,
   output logic [16:0]        rsp_beta_south,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int QW = re_width(RE_LIMIT);

   logic [31:0] density_ff, viscosity_ff, spacing_x_ff, spacing_y_ff;
   logic        adv;

   logic signed [31:0] sum_face [4];
   logic               re_valid [4];
   logic               re_neg   [4];
   logic [QW-1:0]      re_mag   [4];
   logic [3:0]         lane_valid;
   logic signed [15:0] alpha    [4];
   logic [16:0]        beta     [4];

   // Register file; writes are always taken, unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff   <= CSR_RESET_VAL;
         viscosity_ff <= CSR_RESET_VAL;
         spacing_x_ff <= CSR_RESET_VAL;
         spacing_y_ff <= CSR_RESET_VAL;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DENSITY:   density_ff   <= csr_data;
            CSR_VISCOSITY: viscosity_ff <= csr_data;
            CSR_SPACING_X: spacing_x_ff <= csr_data;
            CSR_SPACING_Y: spacing_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Global advance: everything moves unless a finished word is held at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // face order matches the mask bits: east, west, north, south
   assign sum_face[0] = req_sum_east;
   assign sum_face[1] = req_sum_west;
   assign sum_face[2] = req_sum_north;
   assign sum_face[3] = req_sum_south;

   for (genvar f = 0; f < 4; f++) begin : g_lane
      wfc_reyn #(.RE_LIMIT(RE_LIMIT)) u_reyn (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (req_valid),
         .in_sum    (sum_face[f]),
         .in_use_dy (req_use_dy_mask[f]),
         .density   (density_ff),
         .viscosity (viscosity_ff),
         .spacing_x (spacing_x_ff),
         .spacing_y (spacing_y_ff),
         .out_valid (re_valid[f]),
         .out_neg   (re_neg[f]),
         .out_re    (re_mag[f])
      );

      wfc_coef #(.RE_LIMIT(RE_LIMIT)) u_coef (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (re_valid[f]),
         .in_neg    (re_neg[f]),
         .in_re     (re_mag[f]),
         .out_valid (lane_valid[f]),
         .out_alpha (alpha[f]),
         .out_beta  (beta[f])
      );
   end

   // lanes run in lockstep; the valid bits always agree
   assign rsp_valid       = &lane_valid;
   assign rsp_alpha_east  = alpha[0];
   assign rsp_alpha_west  = alpha[1];
   assign rsp_alpha_north = alpha[2];
   assign rsp_alpha_south = alpha[3];
   assign rsp_beta_east   = beta[0];
   assign rsp_beta_west   = beta[1];
   assign rsp_beta_north  = beta[2];
   assign rsp_beta_south  = beta[3];

endmodule

// ===== rtl/wfc_reyn.sv =====
// One face: |Re| from face sum, density, length and viscosity, saturated.
module wfc_reyn import wfc_pkg::*; #(
   parameter int RE_LIMIT = RE_LIMIT_DEF,
   localparam int QW = re_width(RE_LIMIT)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [31:0]  in_sum,
   input  logic                in_use_dy,
   input  logic [31:0]         density,
   input  logic [31:0]         viscosity,
   input  logic [31:0]         spacing_x,
   input  logic [31:0]         spacing_y,
   output logic                out_valid,
   output logic                out_neg,
   output logic [QW-1:0]       out_re
);

   localparam int NW = 96 - 17;     // product scaled by 2^-17
   localparam int HW = NW - QW;
   localparam logic [QW-1:0] CAP = QW'(longint'(RE_LIMIT) << FRAC_BITS);

   // stage 1: magnitude and length
   logic        v1_ff, neg1_ff;
   logic [31:0] mag1_ff, len1_ff;
   // stage 2: sum * density
   logic        v2_ff, neg2_ff;
   logic [63:0] p2_ff;
   logic [31:0] len2_ff;
   // stage 3: partial products with length
   logic        v3_ff, neg3_ff;
   logic [63:0] a3_ff, b3_ff;
   // stage 4: full product
   logic          v4_ff, neg4_ff, nz4_ff;
   logic [NW-1:0] n4_ff;
   logic [95:0]   n_sum;

   // divider stages, index 0 holds the saturation check
   logic          dv_ff   [0:QW];
   logic          dneg_ff [0:QW];
   logic          dnz_ff  [0:QW];
   logic          dsat_ff [0:QW];
   logic [31:0]   drem_ff [0:QW];
   logic [QW-1:0] dnum_ff [0:QW];

   logic [HW-1:0] hi;
   logic          sat0;

   logic          vo_ff, nego_ff;
   logic [QW-1:0] reo_ff;
   logic [QW-1:0] q_fin;

   assign n_sum = {32'd0, a3_ff} + {b3_ff, 32'd0};
   assign hi    = n4_ff[NW-1:QW];
   assign sat0  = (viscosity == 32'd0) ? nz4_ff : (hi >= HW'(viscosity));
   assign q_fin = dnum_ff[QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         neg1_ff <= in_sum[31];
         mag1_ff <= in_sum[31] ? (~in_sum + 32'd1) : in_sum;
         len1_ff <= in_use_dy ? spacing_y : spacing_x;
         neg2_ff <= neg1_ff;
         p2_ff   <= 64'(mag1_ff) * 64'(density);
         len2_ff <= len1_ff;
         neg3_ff <= neg2_ff;
         a3_ff   <= 64'(p2_ff[31:0]) * 64'(len2_ff);
         b3_ff   <= 64'(p2_ff[63:32]) * 64'(len2_ff);
         neg4_ff <= neg3_ff;
         n4_ff   <= n_sum[95:17];
         nz4_ff  <= (n_sum != 96'd0);
      end
   end

   // stage 5: range check; once hi < viscosity the quotient fits QW bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= v4_ff;
      end
      if (adv) begin
         dneg_ff[0] <= neg4_ff;
         dnz_ff[0]  <= nz4_ff;
         dsat_ff[0] <= sat0;
         drem_ff[0] <= sat0 ? 32'd0 : hi[31:0];
         dnum_ff[0] <= n4_ff[QW-1:0];
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [32:0] t;
      logic        ge;
      logic [32:0] diff;
      assign t    = {drem_ff[j], dnum_ff[j][QW-1]};
      assign ge   = (t >= {1'b0, viscosity});
      assign diff = t - {1'b0, viscosity};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
         if (adv) begin
            dneg_ff[j+1] <= dneg_ff[j];
            dnz_ff[j+1]  <= dnz_ff[j];
            dsat_ff[j+1] <= dsat_ff[j];
            drem_ff[j+1] <= ge ? diff[31:0] : t[31:0];
            dnum_ff[j+1] <= {dnum_ff[j][QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= dv_ff[QW];
      end
      if (adv) begin
         nego_ff <= dneg_ff[QW];
         if (!dnz_ff[QW])
            reo_ff <= '0;
         else if (dsat_ff[QW] || (q_fin > CAP))
            reo_ff <= CAP;
         else
            reo_ff <= q_fin;
      end
   end

   assign out_valid = vo_ff;
   assign out_neg   = nego_ff;
   assign out_re    = reo_ff;

endmodule

// ===== rtl/wfc_coef.sv =====
// One face: Re^2, then alpha and beta by pipelined restoring division.
module wfc_coef import wfc_pkg::*; #(
   parameter int RE_LIMIT = RE_LIMIT_DEF,
   localparam int QW = re_width(RE_LIMIT)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic               in_neg,
   input  logic [QW-1:0]      in_re,
   output logic               out_valid,
   output logic signed [15:0] out_alpha,
   output logic [16:0]        out_beta
);

   localparam int RHW = QW - FRAC_BITS;
   localparam int SW  = 2 * QW - FRAC_BITS;
   localparam int DW  = SW + 5;
   localparam int NST = 16;

   // stage 1: partial products of the square
   logic             v1_ff, neg1_ff;
   logic [2*RHW-1:0] hh1_ff;
   logic [RHW+15:0]  hl1_ff;
   logic [31:0]      ll1_ff;
   // stage 2: Re^2 in Q(2*QW-32).16, Q26.16 at the default
   logic             v2_ff, neg2_ff;
   logic [SW-1:0]    s2_ff;

   logic          sv_ff   [0:NST];
   logic          sneg_ff [0:NST];
   logic [DW-1:0] arem_ff [0:NST];
   logic [DW-1:0] aden_ff [0:NST];
   logic [14:0]   qa_ff   [0:NST];
   logic [DW-1:0] brem_ff [0:NST];
   logic [DW-1:0] bden_ff [0:NST];
   logic [16:0]   qb_ff   [0:NST];

   logic [DW-1:0] b_num, b_den;
   logic          b_ge0;

   logic               vo_ff;
   logic signed [15:0] alpha_ff;
   logic [16:0]        beta_ff;

   assign b_num = DW'(BETA_OFS) + DW'(s2_ff);
   assign b_den = DW'(BETA_OFS) + DW'({s2_ff, 3'b000}) + DW'({s2_ff, 1'b0});
   assign b_ge0 = (b_num >= b_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         sv_ff[0] <= v2_ff;
      end
      if (adv) begin
         neg1_ff <= in_neg;
         hh1_ff  <= (2*RHW)'(in_re[QW-1:16]) * (2*RHW)'(in_re[QW-1:16]);
         hl1_ff  <= (RHW+16)'(in_re[QW-1:16]) * (RHW+16)'(in_re[15:0]);
         ll1_ff  <= 32'(in_re[15:0]) * 32'(in_re[15:0]);
         neg2_ff <= neg1_ff;
         s2_ff   <= SW'({hh1_ff, 16'd0}) + SW'({hl1_ff, 1'b0}) + SW'(ll1_ff[31:16]);
         // division setup
         sneg_ff[0] <= neg2_ff;
         arem_ff[0] <= DW'(s2_ff);
         aden_ff[0] <= DW'(ALPHA_OFS) + DW'(s2_ff);
         qa_ff[0]   <= '0;
         brem_ff[0] <= b_ge0 ? (b_num - b_den) : b_num;
         bden_ff[0] <= b_den;
         qb_ff[0]   <= 17'(b_ge0);
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_div
      logic [DW:0] ta, tb, da, db;
      logic        gea, geb;
      assign ta  = {arem_ff[k], 1'b0};
      assign tb  = {brem_ff[k], 1'b0};
      assign gea = (ta >= {1'b0, aden_ff[k]});
      assign geb = (tb >= {1'b0, bden_ff[k]});
      assign da  = ta - {1'b0, aden_ff[k]};
      assign db  = tb - {1'b0, bden_ff[k]};
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[k+1] <= sv_ff[k];
         end
         if (adv) begin
            sneg_ff[k+1] <= sneg_ff[k];
            aden_ff[k+1] <= aden_ff[k];
            bden_ff[k+1] <= bden_ff[k];
            brem_ff[k+1] <= geb ? db[DW-1:0] : tb[DW-1:0];
            qb_ff[k+1]   <= {qb_ff[k][15:0], geb};
         end
      end
      // alpha has 15 quotient bits; the last stage just holds it
      if (k < 15) begin : g_a
         always_ff @(posedge clock) begin
            if (adv) begin
               arem_ff[k+1] <= gea ? da[DW-1:0] : ta[DW-1:0];
               qa_ff[k+1]   <= {qa_ff[k][13:0], gea};
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (adv) begin
               arem_ff[k+1] <= arem_ff[k];
               qa_ff[k+1]   <= qa_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= sv_ff[NST];
      end
      if (adv) begin
         alpha_ff <= sneg_ff[NST] ? -$signed({1'b0, qa_ff[NST]})
                                  : $signed({1'b0, qa_ff[NST]});
         beta_ff  <= qb_ff[NST];
      end
   end

   assign out_valid = vo_ff;
   assign out_alpha = alpha_ff;
   assign out_beta  = beta_ff;

endmodule

// ===== rtl/wfc_check.sv =====
// Port-level checks for the WUDS coefficient block, bound to the top level.
module wfc_check (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_alpha_east,
   input logic [16:0]        rsp_beta_east,
   input logic [16:0]        rsp_beta_west,
   input logic [16:0]        rsp_beta_north,
   input logic [16:0]        rsp_beta_south
);

   // held word stays valid and keeps its east beta
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beta_east))
      else $error("held response changed");

   // input is stalled only behind a held result
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // beta never exceeds 1.0
   a_beta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_beta_east <= 17'd65536 && rsp_beta_west <= 17'd65536 &&
                    rsp_beta_north <= 17'd65536 && rsp_beta_south <= 17'd65536)
      else $error("beta above one");

   // beta of exactly one means Re^2 is zero, so alpha is zero too
   a_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beta_east == 17'd65536 |-> rsp_alpha_east == 16'sd0)
      else $error("alpha nonzero at zero Reynolds number");

endmodule

bind wuds_face_coefficients wfc_check u_wfc_check (.*);

// ===== sim/wfc_checker.sv =====
// Checker for the WUDS face coefficient block: predicts each word and compares it.
`timescale 1ns / 100ps
module wfc_checker import wfc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_sum_east,
   input  logic signed [31:0] req_sum_west,
   input  logic signed [31:0] req_sum_north,
   input  logic signed [31:0] req_sum_south,
   input  logic [3:0]         req_use_dy_mask,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [15:0] rsp_alpha_east,
   input  logic signed [15:0] rsp_alpha_west,
   input  logic signed [15:0] rsp_alpha_north,
   input  logic signed [15:0] rsp_alpha_south,
   input  logic [16:0]        rsp_beta_east,
   input  logic [16:0]        rsp_beta_west,
   input  logic [16:0]        rsp_beta_north,
   input  logic [16:0]        rsp_beta_south,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 words_checked
);

   typedef struct packed {
      logic [3:0][15:0] alpha;
      logic [3:0][16:0] beta;
   } coeff_word_type;

   logic [31:0] density_q, viscosity_q, spacing_x_q, spacing_y_q;
   coeff_word_type coeff_queue[$];

   function automatic void face_coeff(input logic [31:0] raw_sum, input logic use_dy,
                                      output logic [15:0] alpha, output logic [16:0] beta);
      logic            neg;
      logic [31:0]     mag_sum, len;
      logic [127:0]    prod, re_full;
      logic [63:0]     cap, re_mag, sq, amag, bnum, bden, bq;
      neg     = raw_sum[31];
      mag_sum = neg ? -raw_sum : raw_sum;
      len     = use_dy ? spacing_y_q : spacing_x_q;
      cap     = 64'(RE_LIMIT_DEF) << 16;
      prod    = 128'(mag_sum) * 128'(density_q) * 128'(len);
      if (viscosity_q == 0)
         re_mag = (prod != 0) ? cap : 64'd0;
      else begin
         re_full = prod / (128'(viscosity_q) << 17);
         re_mag  = (re_full > 128'(cap)) ? cap : re_full[63:0];
      end
      sq    = (re_mag * re_mag) >> 16;
      amag  = (sq << 15) / (ALPHA_OFS + sq);
      alpha = (neg && re_mag != 0) ? 16'(-amag) : amag[15:0];
      bnum  = (BETA_OFS + sq) << 16;
      bden  = BETA_OFS + 10 * sq;
      bq    = bnum / bden;
      beta  = (bq > 64'd65536) ? 17'd65536 : bq[16:0];
   endfunction

   function automatic coeff_word_type predict_coeffs(input logic [3:0][31:0] sums,
                                                     input logic [3:0] mask);
      coeff_word_type w;
      for (int f = 0; f < 4; f++) face_coeff(sums[f], mask[f], w.alpha[f], w.beta[f]);
      return w;
   endfunction

   always @(posedge clock) begin
      coeff_word_type exp_w, got;
      logic           mism;
      if (reset) begin
         density_q     <= CSR_RESET_VAL;
         viscosity_q   <= CSR_RESET_VAL;
         spacing_x_q   <= CSR_RESET_VAL;
         spacing_y_q   <= CSR_RESET_VAL;
         fail_count    <= 0;
         words_checked <= 0;
         pending       <= 0;
         coeff_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DENSITY:   density_q   <= csr_data;
               CSR_VISCOSITY: viscosity_q <= csr_data;
               CSR_SPACING_X: spacing_x_q <= csr_data;
               CSR_SPACING_Y: spacing_y_q <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            coeff_queue.push_back(predict_coeffs({req_sum_south, req_sum_north,
                                                  req_sum_west, req_sum_east},
                                                 req_use_dy_mask));
         if (rsp_valid && !rsp_stall) begin
            got.alpha = {rsp_alpha_south, rsp_alpha_north, rsp_alpha_west, rsp_alpha_east};
            got.beta  = {rsp_beta_south, rsp_beta_north, rsp_beta_west, rsp_beta_east};
            words_checked <= words_checked + 1;
            if (coeff_queue.size() == 0) begin
               if (fail_count < 10) $display("checker: unexpected result word");
               fail_count <= fail_count + 1;
            end else begin
               exp_w = coeff_queue.pop_front();
               mism  = 1'b0;
               for (int f = 0; f < 4; f++) begin
                  if (got.alpha[f] !== exp_w.alpha[f] || got.beta[f] !== exp_w.beta[f]) begin
                     if (fail_count < 10 && !mism)
                        $display("checker: face %0d alpha exp %h got %h, beta exp %h got %h",
                                 f, exp_w.alpha[f], got.alpha[f], exp_w.beta[f], got.beta[f]);
                     mism = 1'b1;
                  end
               end
               if (mism) fail_count <= fail_count + 1;
            end
         end
         pending <= coeff_queue.size();
      end
   end

endmodule

// ===== sim/tb_wuds_face_coefficients.sv =====
// Testbench top: drives volume words and register writes, gives the verdict.
`timescale 1ns / 100ps
module tb_wuds_face_coefficients;
   import wfc_pkg::*;

   // pipeline depth at the default limit is 29 + 26
   localparam int DRAIN_CYCLES = 80;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_valid, csr_ready;
   logic signed [31:0] req_sum_east, req_sum_west, req_sum_north, req_sum_south;
   logic [3:0] req_use_dy_mask;
   logic signed [15:0] rsp_alpha_east, rsp_alpha_west, rsp_alpha_north, rsp_alpha_south;
   logic [16:0] rsp_beta_east, rsp_beta_west, rsp_beta_north, rsp_beta_south;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;
   int fail_count, pending, words_checked;
   int words_sent;

   wuds_face_coefficients dut (.*);
   wfc_checker chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit, far beyond a slow but correct run
   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

   // receiver stall pattern: mode changes every so often (none / light / heavy)
   int stall_mode;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Random velocity sum; half moderate, else fully random, extremes or zero walls
   function automatic logic [31:0] rand_sum();
      case ($urandom_range(0, 9))
         0: return 32'd0;
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         3, 4: return $urandom();
         5: return -($urandom_range(0, 32'h0004_0000));
         default: return $urandom_range(0, 32'h0004_0000) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
   endfunction

   task automatic send_word(input logic [31:0] e, w, n, s, input logic [3:0] m);
      req_valid       <= 1'b1;
      req_sum_east    <= e;
      req_sum_west    <= w;
      req_sum_north   <= n;
      req_sum_south   <= s;
      req_use_dy_mask <= m;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait for every word to return, then let the pipeline settle
   task automatic drain();
      idle_gap(1);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_burst_run(input int count);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && left > 0; k++, left--)
            send_word(rand_sum(), rand_sum(), rand_sum(), rand_sum(),
                      4'($urandom_range(0, 15)));
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
      end
   endtask

   initial begin
      req_valid = 0; req_sum_east = 0; req_sum_west = 0; req_sum_north = 0;
      req_sum_south = 0; req_use_dy_mask = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      words_sent = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wall faces, extremes, sign, mask bits, at reset values
      send_word(0, 0, 0, 0, 4'h0);
      send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 4'hF);
      send_word(32'h0001_0000, -32'sh0001_0000, 32'h0014_0000, -32'sh0014_0000, 4'h5);
      send_word(32'h0000_8000, 32'h000A_0000, 32'h0100_0000, 32'h1000_0000, 4'hA);
      drain();

      // distinct spacings so the mask matters; zero viscosity saturates
      write_reg(CSR_SPACING_X, 32'h0000_4000);
      write_reg(CSR_SPACING_Y, 32'h0004_0000);
      write_reg(CSR_VISCOSITY, 32'd0);
      write_reg(CSR_DENSITY, 32'h0002_0000);
      write_reg(csr_index_type'(8'd7), 32'hDEAD_BEEF);  // out-of-range index, ignored
      send_word(0, 32'h0001_0000, -32'sh0000_0001, 32'h7FFF_FFFF, 4'h3);
      send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 4'h6);
      drain();

      // maximum density, viscosity and x spacing with zero y spacing, then minimum nonzero viscosity
      write_reg(CSR_DENSITY, 32'hFFFF_FFFF);
      write_reg(CSR_VISCOSITY, 32'hFFFF_FFFF);
      write_reg(CSR_SPACING_X, 32'hFFFF_FFFF);
      write_reg(CSR_SPACING_Y, 32'd0);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 4'h0);
      send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 4'hF);
      drain();
      write_reg(CSR_VISCOSITY, 32'd1);
      send_word(32'h0000_0001, 32'h8000_0000, 0, -32'sh0000_0001, 4'h9);
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_DENSITY, (ph == 0) ? CSR_RESET_VAL : $urandom_range(32'h100, 32'h40000));
         write_reg(CSR_VISCOSITY, (ph == 0) ? CSR_RESET_VAL
                                            : $urandom_range(32'h100, 32'h40000));
         write_reg(CSR_SPACING_X, (ph == 5) ? $urandom() : $urandom_range(0, 32'h40000));
         write_reg(CSR_SPACING_Y, (ph == 5) ? $urandom() : $urandom_range(0, 32'h40000));
         random_burst_run(220);
         drain();
      end

      idle_gap(1);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: sent %0d volume words, checked %0d, across 10 register settings",
               words_sent, words_checked);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
